>>> hdl/raw_sample_swap_and_scale_macros.svh
// Assertion macros used by the top RTL file of the sample converter.
// No dependencies.
`ifndef RAW_SAMPLE_SWAP_AND_SCALE_MACROS_SVH
`define RAW_SAMPLE_SWAP_AND_SCALE_MACROS_SVH

// Same-cycle implication
`define RSSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsss assertion failed");

// Next-cycle implication
`define RSSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsss assertion failed");

`endif

>>> hdl/rsss_pkg.sv
// Shared types, codes and helper functions of the sample converter.
// No dependencies.
package rsss_pkg;

    localparam logic [2:0] FMT_F64 = 3'd0;
    localparam logic [2:0] FMT_F32 = 3'd1;
    localparam logic [2:0] FMT_S16 = 3'd2;
    localparam logic [2:0] FMT_U16 = 3'd3;
    localparam logic [2:0] FMT_S32 = 3'd4;
    localparam logic [2:0] FMT_U32 = 3'd5;
    localparam logic [2:0] FMT_S64 = 3'd6;
    localparam logic [2:0] FMT_U64 = 3'd7;

    localparam logic [2:0] REG_SWAP   = 3'd0;
    localparam logic [2:0] REG_FORMAT = 3'd1;
    localparam logic [2:0] REG_SCALE  = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_STRIDE = 3'd4;

    localparam int DEST_W = 48;

    localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

    typedef struct packed {
        logic signed [DEST_W-1:0] dest_offset;
        logic                     last;
    } tag_t;

    // leading zero count from bit 127; 128 when all zero
    function automatic logic [7:0] lzc128(input logic [127:0] v);
        logic [7:0] n;
        n = 8'd128;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                n = 8'(127 - i);
            end
        end
        return n;
    endfunction

endpackage

>>> hdl/rsss_if.sv
// Handshake interfaces of the sample converter: sample input, result output, config.
// No dependencies.
interface rsss_sample_if #(parameter int INDEX_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [63:0]            raw_word;
    logic [INDEX_WIDTH-1:0] element_index;
    logic                   last_item;
    modport source (output valid, raw_word, element_index, last_item, input ready);
    modport sink (input valid, raw_word, element_index, last_item, output ready);
endinterface

interface rsss_result_if;
    logic               valid;
    logic               ready;
    logic [63:0]        scaled_value;
    logic signed [47:0] dest_offset;
    logic               last_out;
    modport source (output valid, scaled_value, dest_offset, last_out, input ready);
    modport sink (input valid, scaled_value, dest_offset, last_out, output ready);
endinterface

interface rsss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/rsss_cvt.sv
// Four-stage converter: byte swap, format decode, normalize and round to double.
// Depends on rsss_pkg.
module rsss_cvt
    import rsss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [63:0] raw_word,
    input  tag_t        tag_in,
    input  logic        swap_bytes,
    input  logic [2:0]  sample_format,
    output logic        out_valid,
    output logic [63:0] out_bits,
    output tag_t        tag_out
);

    logic [63:0] rev, masked, v;
    logic        byp_next, sign_next;
    logic [63:0] bits_next, mag_next;
    logic [10:0] base_next;

    always_comb
    begin
        case (sample_format)
            FMT_S16, FMT_U16:
            begin
                rev    = {48'b0, raw_word[7:0], raw_word[15:8]};
                masked = {48'b0, raw_word[15:0]};
            end
            FMT_F32, FMT_S32, FMT_U32:
            begin
                rev    = {32'b0, raw_word[7:0], raw_word[15:8], raw_word[23:16],
                          raw_word[31:24]};
                masked = {32'b0, raw_word[31:0]};
            end
            default:
            begin
                rev    = {raw_word[7:0], raw_word[15:8], raw_word[23:16], raw_word[31:24],
                          raw_word[39:32], raw_word[47:40], raw_word[55:48],
                          raw_word[63:56]};
                masked = raw_word;
            end
        endcase
        v = swap_bytes ? rev : masked;

        byp_next  = 1'b1;
        bits_next = 64'b0;
        sign_next = 1'b0;
        mag_next  = 64'b0;
        base_next = 11'd1023;
        case (sample_format)
            FMT_F64:
            begin
                bits_next = v;
            end
            FMT_F32:
            begin
                if (v[30:23] == 8'hFF)
                begin
                    bits_next = {v[31], 11'h7FF, v[22] | (|v[22:0]), v[21:0], 29'b0};
                end
                else if (v[30:23] == 8'h00)
                begin
                    if (v[22:0] == 23'b0)
                    begin
                        bits_next = {v[31], 63'b0};
                    end
                    else
                    begin
                        // single subnormal: normalize like an integer
                        byp_next  = 1'b0;
                        sign_next = v[31];
                        mag_next  = {41'b0, v[22:0]};
                        base_next = 11'd874;
                    end
                end
                else
                begin
                    bits_next = {v[31], {3'b0, v[30:23]} + 11'd896, v[22:0], 29'b0};
                end
            end
            FMT_S16:
            begin
                byp_next  = 1'b0;
                sign_next = v[15];
                mag_next  = v[15] ? 64'd0 - {{48{v[15]}}, v[15:0]} : {48'b0, v[15:0]};
            end
            FMT_S32:
            begin
                byp_next  = 1'b0;
                sign_next = v[31];
                mag_next  = v[31] ? 64'd0 - {{32{v[31]}}, v[31:0]} : {32'b0, v[31:0]};
            end
            FMT_S64:
            begin
                byp_next  = 1'b0;
                sign_next = v[63];
                mag_next  = v[63] ? 64'd0 - v : v;
            end
            FMT_U16, FMT_U32, FMT_U64:
            begin
                byp_next = 1'b0;
                mag_next = v;
            end
            default:
            begin
                bits_next = v;
            end
        endcase
    end

    // stage 1
    logic        v1_reg, byp1_reg, sign1_reg;
    logic [63:0] bits1_reg, mag1_reg;
    logic [10:0] base1_reg;
    tag_t        tag1_reg;

    // stage 2
    logic        v2_reg, byp2_reg, sign2_reg;
    logic [63:0] bits2_reg, mag2_reg;
    logic [10:0] base2_reg;
    logic [5:0]  lz2_reg;
    tag_t        tag2_reg;

    // stage 3
    logic        v3_reg, byp3_reg, sign3_reg;
    logic [63:0] bits3_reg, n3_reg;
    logic [10:0] exp3_reg;
    tag_t        tag3_reg;

    // stage 4
    logic        v4_reg;
    logic [63:0] out4_reg;
    tag_t        tag4_reg;

    logic [7:0]  lz_full;
    logic        zero2_next;
    logic        inc4_next;
    logic [63:0] out4_next;

    assign lz_full    = lzc128({mag1_reg, 64'b0});
    assign zero2_next = (mag1_reg == 64'b0);
    assign inc4_next  = n3_reg[10] & ((|n3_reg[9:0]) | n3_reg[11]);
    assign out4_next  = byp3_reg ? bits3_reg
                      : {sign3_reg, exp3_reg, n3_reg[62:11]} + {63'b0, inc4_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp1_reg  <= byp_next;
            bits1_reg <= bits_next;
            sign1_reg <= sign_next;
            mag1_reg  <= mag_next;
            base1_reg <= base_next;
            tag1_reg  <= tag_in;

            byp2_reg  <= byp1_reg | zero2_next;
            bits2_reg <= byp1_reg ? bits1_reg : 64'b0;
            sign2_reg <= sign1_reg;
            mag2_reg  <= mag1_reg;
            base2_reg <= base1_reg;
            lz2_reg   <= lz_full[5:0];
            tag2_reg  <= tag1_reg;

            byp3_reg  <= byp2_reg;
            bits3_reg <= bits2_reg;
            sign3_reg <= sign2_reg;
            n3_reg    <= mag2_reg << lz2_reg;
            exp3_reg  <= base2_reg + 11'd63 - {5'b0, lz2_reg};
            tag3_reg  <= tag2_reg;

            out4_reg  <= out4_next;
            tag4_reg  <= tag3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_bits  = out4_reg;
    assign tag_out   = tag4_reg;

endmodule

>>> hdl/rsss_fmul.sv
// Six-stage IEEE double multiplier, round to nearest even, subnormals kept.
// Depends on rsss_pkg.
module rsss_fmul
    import rsss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [63:0] a_bits,
    input  logic [63:0] b_bits,
    input  tag_t        tag_in,
    output logic        out_valid,
    output logic [63:0] out_bits,
    output tag_t        tag_out
);

    logic [10:0] ea, eb, ea1, eb1;
    logic [52:0] sig_a, sig_b;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, s_next;
    logic        spec_next;
    logic [63:0] spec_bits_next;
    logic [11:0] esum_next;
    logic [51:0] hh_next;
    logic [52:0] hl_next, lh_next;
    logic [53:0] ll_next;

    always_comb
    begin
        ea     = a_bits[62:52];
        eb     = b_bits[62:52];
        ea1    = (ea == 11'd0) ? 11'd1 : ea;
        eb1    = (eb == 11'd0) ? 11'd1 : eb;
        sig_a  = {ea != 11'd0, a_bits[51:0]};
        sig_b  = {eb != 11'd0, b_bits[51:0]};
        nan_a  = (ea == 11'h7FF) && (a_bits[51:0] != 52'b0);
        nan_b  = (eb == 11'h7FF) && (b_bits[51:0] != 52'b0);
        inf_a  = (ea == 11'h7FF) && (a_bits[51:0] == 52'b0);
        inf_b  = (eb == 11'h7FF) && (b_bits[51:0] == 52'b0);
        zero_a = (a_bits[62:0] == 63'b0);
        zero_b = (b_bits[62:0] == 63'b0);
        s_next = a_bits[63] ^ b_bits[63];
        esum_next = {1'b0, ea1} + {1'b0, eb1};

        spec_next      = 1'b1;
        spec_bits_next = 64'b0;
        if (nan_a)
        begin
            spec_bits_next = a_bits | QUIET_BIT;
        end
        else if (nan_b)
        begin
            spec_bits_next = b_bits | QUIET_BIT;
        end
        else if ((inf_a && zero_b) || (zero_a && inf_b))
        begin
            spec_bits_next = QNAN_DEFAULT;
        end
        else if (inf_a || inf_b)
        begin
            spec_bits_next = {s_next, 11'h7FF, 52'b0};
        end
        else if (zero_a || zero_b)
        begin
            spec_bits_next = {s_next, 63'b0};
        end
        else
        begin
            spec_next = 1'b0;
        end

        hh_next = sig_a[52:27] * sig_b[52:27];
        hl_next = sig_a[52:27] * sig_b[26:0];
        lh_next = sig_a[26:0] * sig_b[52:27];
        ll_next = sig_a[26:0] * sig_b[26:0];
    end

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic        s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic        sp1_reg, sp2_reg, sp3_reg, sp4_reg, sp5_reg;
    logic [63:0] spb1_reg, spb2_reg, spb3_reg, spb4_reg, spb5_reg;
    tag_t        tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;
    logic [11:0] esum1_reg, esum2_reg, esum3_reg;
    logic [51:0] hh1_reg;
    logic [52:0] hl1_reg, lh1_reg;
    logic [53:0] ll1_reg;
    logic [105:0] p2_reg, p3_reg, n4_reg, nr5_reg;
    logic [6:0]  lz3_reg;
    logic signed [12:0] e4_reg;
    logic        st5_reg, ovf5_reg;
    logic [10:0] field5_reg;
    logic [63:0] out6_reg;

    logic [105:0] p_next;
    logic [7:0]   lz_full;
    logic signed [12:0] e_next, one_minus;
    logic [6:0]   rs;
    logic [211:0] ext;
    logic         inc6_next;
    logic [63:0]  out6_next;

    always_comb
    begin
        p_next  = {hh1_reg, 54'b0} + {26'b0, hl1_reg, 27'b0} + {26'b0, lh1_reg, 27'b0}
                + {52'b0, ll1_reg};
        lz_full = lzc128({p2_reg, 22'b0});
        e_next  = $signed({1'b0, esum3_reg}) - 13'sd1022 - $signed({6'b0, lz3_reg});

        one_minus = 13'sd1 - e4_reg;
        if (e4_reg >= 13'sd1)
        begin
            rs = 7'd0;
        end
        else if (e4_reg <= -13'sd105)
        begin
            rs = 7'd106;
        end
        else
        begin
            rs = one_minus[6:0];
        end
        ext = {n4_reg, 106'b0} >> rs;

        inc6_next = nr5_reg[52] & ((|nr5_reg[51:0]) | st5_reg | nr5_reg[53]);
        if (sp5_reg)
        begin
            out6_next = spb5_reg;
        end
        else if (ovf5_reg)
        begin
            out6_next = {s5_reg, 11'h7FF, 52'b0};
        end
        else
        begin
            out6_next = {s5_reg, field5_reg, nr5_reg[104:53]} + {63'b0, inc6_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= s_next;
            sp1_reg   <= spec_next;
            spb1_reg  <= spec_bits_next;
            tag1_reg  <= tag_in;
            esum1_reg <= esum_next;
            hh1_reg   <= hh_next;
            hl1_reg   <= hl_next;
            lh1_reg   <= lh_next;
            ll1_reg   <= ll_next;

            s2_reg    <= s1_reg;
            sp2_reg   <= sp1_reg;
            spb2_reg  <= spb1_reg;
            tag2_reg  <= tag1_reg;
            esum2_reg <= esum1_reg;
            p2_reg    <= p_next;

            s3_reg    <= s2_reg;
            sp3_reg   <= sp2_reg;
            spb3_reg  <= spb2_reg;
            tag3_reg  <= tag2_reg;
            esum3_reg <= esum2_reg;
            p3_reg    <= p2_reg;
            lz3_reg   <= lz_full[6:0];

            s4_reg    <= s3_reg;
            sp4_reg   <= sp3_reg;
            spb4_reg  <= spb3_reg;
            tag4_reg  <= tag3_reg;
            n4_reg    <= p3_reg << lz3_reg;
            e4_reg    <= e_next;

            s5_reg     <= s4_reg;
            sp5_reg    <= sp4_reg;
            spb5_reg   <= spb4_reg;
            tag5_reg   <= tag4_reg;
            nr5_reg    <= ext[211:106];
            st5_reg    <= |ext[105:0];
            field5_reg <= (e4_reg >= 13'sd1) ? e4_reg[10:0] : 11'd0;
            ovf5_reg   <= (e4_reg >= 13'sd2047);

            out6_reg <= out6_next;
            tag6_reg <= tag5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_bits  = out6_reg;
    assign tag_out   = tag6_reg;

endmodule

>>> hdl/rsss_fadd.sv
// Six-stage IEEE double adder, round to nearest even, subnormals kept.
// Depends on rsss_pkg.
module rsss_fadd
    import rsss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [63:0] a_bits,
    input  logic [63:0] b_bits,
    input  tag_t        tag_in,
    output logic        out_valid,
    output logic [63:0] out_bits,
    output tag_t        tag_out
);

    logic [10:0] ea, eb, ex, ey, ex1, ey1;
    logic        nan_a, nan_b, inf_a, inf_b, swp;
    logic [63:0] xb, yb;
    logic        spec_next;
    logic [63:0] spec_bits_next;

    always_comb
    begin
        ea    = a_bits[62:52];
        eb    = b_bits[62:52];
        nan_a = (ea == 11'h7FF) && (a_bits[51:0] != 52'b0);
        nan_b = (eb == 11'h7FF) && (b_bits[51:0] != 52'b0);
        inf_a = (ea == 11'h7FF) && (a_bits[51:0] == 52'b0);
        inf_b = (eb == 11'h7FF) && (b_bits[51:0] == 52'b0);
        swp   = b_bits[62:0] > a_bits[62:0];
        xb    = swp ? b_bits : a_bits;
        yb    = swp ? a_bits : b_bits;
        ex    = xb[62:52];
        ey    = yb[62:52];
        ex1   = (ex == 11'd0) ? 11'd1 : ex;
        ey1   = (ey == 11'd0) ? 11'd1 : ey;

        spec_next      = 1'b1;
        spec_bits_next = 64'b0;
        if (nan_a)
        begin
            spec_bits_next = a_bits | QUIET_BIT;
        end
        else if (nan_b)
        begin
            spec_bits_next = b_bits | QUIET_BIT;
        end
        else if (inf_a && inf_b && (a_bits[63] != b_bits[63]))
        begin
            spec_bits_next = QNAN_DEFAULT;
        end
        else if (inf_a)
        begin
            spec_bits_next = a_bits;
        end
        else if (inf_b)
        begin
            spec_bits_next = b_bits;
        end
        else
        begin
            spec_next = 1'b0;
        end
    end

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic        sx1_reg, sx2_reg, sx3_reg, sx4_reg, sx5_reg;
    logic        zs1_reg, zs2_reg, zs3_reg, zs4_reg, zs5_reg;
    logic        sp1_reg, sp2_reg, sp3_reg, sp4_reg, sp5_reg;
    logic [63:0] spb1_reg, spb2_reg, spb3_reg, spb4_reg, spb5_reg;
    tag_t        tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;
    logic [10:0] ex1_reg, ex2_reg, ex3_reg, ex4_reg;
    logic        sub1_reg, sub2_reg;
    logic [10:0] d1_reg;
    logic [52:0] mx1_reg, my1_reg;
    logic [55:0] xm2_reg, ya2_reg;
    logic [56:0] s3_reg, s4_reg;
    logic [7:0]  lz4_reg;
    logic        sz4_reg, sz5_reg, ovf5_reg;
    logic [55:0] n5_reg;
    logic [10:0] field5_reg;
    logic [63:0] out6_reg;

    logic [5:0]   dc;
    logic [111:0] ext;
    logic [55:0]  ya_next;
    logic [56:0]  s_next;
    logic [7:0]   lz_full;
    logic [10:0]  lz11, sh11;
    logic [55:0]  n_next;
    logic [11:0]  exp_next;
    logic         inc6_next;
    logic [63:0]  out6_next;

    always_comb
    begin
        dc      = (d1_reg > 11'd56) ? 6'd56 : d1_reg[5:0];
        ext     = {my1_reg, 59'b0} >> dc;
        ya_next = ext[111:56] | {55'b0, |ext[55:0]};

        s_next  = sub2_reg ? {1'b0, xm2_reg} - {1'b0, ya2_reg}
                           : {1'b0, xm2_reg} + {1'b0, ya2_reg};

        lz_full = lzc128({s3_reg[55:0], 72'b0});

        lz11 = {3'b0, lz4_reg};
        sh11 = (lz11 < ex4_reg) ? lz11 : ex4_reg - 11'd1;
        if (s4_reg[56])
        begin
            n_next   = {s4_reg[56:2], s4_reg[1] | s4_reg[0]};
            exp_next = {1'b0, ex4_reg} + 12'd1;
        end
        else
        begin
            n_next   = s4_reg[55:0] << sh11[5:0];
            exp_next = {1'b0, ex4_reg - sh11};
        end

        inc6_next = n5_reg[2] & (n5_reg[1] | n5_reg[0] | n5_reg[3]);
        if (sp5_reg)
        begin
            out6_next = spb5_reg;
        end
        else if (sz5_reg)
        begin
            out6_next = {zs5_reg, 63'b0};
        end
        else if (ovf5_reg)
        begin
            out6_next = {sx5_reg, 11'h7FF, 52'b0};
        end
        else
        begin
            out6_next = {sx5_reg, field5_reg, n5_reg[54:3]} + {63'b0, inc6_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx1_reg  <= xb[63];
            zs1_reg  <= (a_bits[63] == b_bits[63]) ? a_bits[63] : 1'b0;
            sp1_reg  <= spec_next;
            spb1_reg <= spec_bits_next;
            tag1_reg <= tag_in;
            ex1_reg  <= ex1;
            sub1_reg <= xb[63] ^ yb[63];
            d1_reg   <= ex1 - ey1;
            mx1_reg  <= {ex != 11'd0, xb[51:0]};
            my1_reg  <= {ey != 11'd0, yb[51:0]};

            sx2_reg  <= sx1_reg;
            zs2_reg  <= zs1_reg;
            sp2_reg  <= sp1_reg;
            spb2_reg <= spb1_reg;
            tag2_reg <= tag1_reg;
            ex2_reg  <= ex1_reg;
            sub2_reg <= sub1_reg;
            xm2_reg  <= {mx1_reg, 3'b0};
            ya2_reg  <= ya_next;

            sx3_reg  <= sx2_reg;
            zs3_reg  <= zs2_reg;
            sp3_reg  <= sp2_reg;
            spb3_reg <= spb2_reg;
            tag3_reg <= tag2_reg;
            ex3_reg  <= ex2_reg;
            s3_reg   <= s_next;

            sx4_reg  <= sx3_reg;
            zs4_reg  <= zs3_reg;
            sp4_reg  <= sp3_reg;
            spb4_reg <= spb3_reg;
            tag4_reg <= tag3_reg;
            ex4_reg  <= ex3_reg;
            s4_reg   <= s3_reg;
            lz4_reg  <= lz_full;
            sz4_reg  <= (s3_reg == 57'b0);

            sx5_reg    <= sx4_reg;
            zs5_reg    <= zs4_reg;
            sp5_reg    <= sp4_reg;
            spb5_reg   <= spb4_reg;
            tag5_reg   <= tag4_reg;
            sz5_reg    <= sz4_reg;
            n5_reg     <= n_next;
            field5_reg <= n_next[55] ? exp_next[10:0] : 11'd0;
            ovf5_reg   <= (exp_next >= 12'd2047);

            out6_reg <= out6_next;
            tag6_reg <= tag5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_bits  = out6_reg;
    assign tag_out   = tag6_reg;

endmodule

>>> hdl/raw_sample_swap_and_scale.sv
// Raw sample converter: optional byte swap, conversion of one packed element to an
// IEEE double, then value * scale_factor + offset_value, each step rounded to nearest
// even, with destination offset element_index * output_stride. One item enters per
// clock while the skid entry is empty; the result passes in order through the format
// converter, the multiplier (four partial products of 26- and 27-bit pieces, sum,
// normalize, denormal shift, round), the adder and the output register. A two-entry
// output buffer keeps input acceptance off the output ready path; when it holds two
// results the pipeline stops. Config writes are always taken and must only happen
// while the block is idle. Depends on rsss_pkg, rsss_if and the rsss_* stage modules.
`include "raw_sample_swap_and_scale_macros.svh"

module raw_sample_swap_and_scale
    import rsss_pkg::*;
#(
    parameter int INDEX_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    rsss_sample_if.sink   sample_in,
    rsss_result_if.source result_out,
    rsss_cfg_if.sink      cfg
);

    logic               swap_reg;
    logic [2:0]         format_reg;
    logic [63:0]        scale_reg, offset_reg;
    logic signed [15:0] stride_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg   <= 1'b0;
            format_reg <= FMT_F64;
            scale_reg  <= 64'h3FF0_0000_0000_0000;
            offset_reg <= 64'b0;
            stride_reg <= 16'sd1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SWAP:   swap_reg   <= cfg.data[0];
                REG_FORMAT: format_reg <= cfg.data[2:0];
                REG_SCALE:  scale_reg  <= cfg.data;
                REG_OFFSET: offset_reg <= cfg.data;
                REG_STRIDE: stride_reg <= cfg.data[15:0];
                default:    ;
            endcase
        end
    end

    logic                   adv;
    logic [INDEX_WIDTH-1:0] idx;
    tag_t                   tag_in;

    assign idx                = sample_in.element_index;
    assign tag_in.dest_offset = DEST_W'($signed({1'b0, idx}) * stride_reg);
    assign tag_in.last        = sample_in.last_item;
    assign sample_in.ready    = adv;

    logic        cv_valid, mu_valid, ad_valid;
    logic [63:0] cv_bits, mu_bits, ad_bits;
    tag_t        cv_tag, mu_tag, ad_tag;

    rsss_cvt u_cvt (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (sample_in.valid),
        .raw_word      (sample_in.raw_word),
        .tag_in        (tag_in),
        .swap_bytes    (swap_reg),
        .sample_format (format_reg),
        .out_valid     (cv_valid),
        .out_bits      (cv_bits),
        .tag_out       (cv_tag)
    );

    rsss_fmul u_fmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cv_valid),
        .a_bits    (cv_bits),
        .b_bits    (scale_reg),
        .tag_in    (cv_tag),
        .out_valid (mu_valid),
        .out_bits  (mu_bits),
        .tag_out   (mu_tag)
    );

    rsss_fadd u_fadd (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mu_valid),
        .a_bits    (mu_bits),
        .b_bits    (offset_reg),
        .tag_in    (mu_tag),
        .out_valid (ad_valid),
        .out_bits  (ad_bits),
        .tag_out   (ad_tag)
    );

    // output register plus skid entry
    logic        ov_reg, sv_reg;
    logic [63:0] obits_reg, sbits_reg;
    tag_t        otag_reg, stag_reg;
    logic        hand_next;

    assign adv       = !sv_reg;
    assign hand_next = adv && ad_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (!ov_reg || result_out.ready)
        begin
            if (sv_reg)
            begin
                sv_reg <= 1'b0;
                ov_reg <= 1'b1;
            end
            else
            begin
                ov_reg <= hand_next;
            end
        end
        else if (hand_next)
        begin
            sv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || result_out.ready)
        begin
            if (sv_reg)
            begin
                obits_reg <= sbits_reg;
                otag_reg  <= stag_reg;
            end
            else
            begin
                obits_reg <= ad_bits;
                otag_reg  <= ad_tag;
            end
        end
        else if (hand_next)
        begin
            sbits_reg <= ad_bits;
            stag_reg  <= ad_tag;
        end
    end

    assign result_out.valid        = ov_reg;
    assign result_out.scaled_value = obits_reg;
    assign result_out.dest_offset  = otag_reg.dest_offset;
    assign result_out.last_out     = otag_reg.last;

    `RSSS_ASSERT_IMPL(a_skid_needs_out, clk, rst_n, sv_reg, ov_reg)
    `RSSS_ASSERT_NEXT(a_empty_out_no_skid, clk, rst_n, !ov_reg, !sv_reg)
    `RSSS_ASSERT_NEXT(a_skid_drain_keeps_out, clk, rst_n,
                      ov_reg && result_out.ready && sv_reg, ov_reg)
    `RSSS_ASSERT_NEXT(a_stall_holds_tail, clk, rst_n, ad_valid && !adv, ad_valid)

endmodule
